// File: design/wspq_pkg.sv
// ----------------------------------------------------------------------------
// wspq_pkg
// Shared types, constants and the ordering function for the weight/symbol
// priority queue.
// ----------------------------------------------------------------------------
package wspq_pkg;

   localparam int CAPACITY     = 256;
   localparam int HANDLE_BITS  = 9;
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
   localparam int WEIGHT_BITS  = 32;
   localparam int SYMBOL_BITS  = 8;
   localparam int FIELD_HANDLE = 9;
   localparam int FIELD_COUNT  = 9;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [SYMBOL_BITS-1:0] symbol;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic      shift_in;
      logic      shift_out;
      entry_type item;
   } cmd_type;

   function automatic logic goes_before(entry_type a, entry_type b);
      if (a.weight != b.weight) begin
         return a.weight < b.weight;
      end
      return a.symbol < b.symbol;
   endfunction

endpackage

// File: design/weight_symbol_priority_queue_top.sv
// ----------------------------------------------------------------------------
// weight_symbol_priority_queue_top
// Sorted min-priority queue built from a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns its response in the next cycle; a
// waiting response does not stop the next request unless it is stalled.
// Every request is handled by the single compare-and-shift step that all
// cells of the row take together. Entries are kept ordered by weight, then
// symbol; equal entries queue in arrival order. Enqueue on a full queue or
// dequeue on an empty one leaves it unchanged and is flagged in status.
module weight_symbol_priority_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // item_weight[31:0], item_symbol[39:32],
                                   // item_handle[48:40], zero pad
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // out_weight[31:0], out_symbol[39:32],
                                   // out_handle[48:40], entry_count[57:49],
                                   // queue_empty[58], size_is_one[59], pad
   output logic [1:0]  rsp_tuser   // status
);

   localparam int N = wspq_pkg::CAPACITY;

   logic [wspq_pkg::COUNT_BITS-1:0]     occ_ff;
   logic [wspq_pkg::COUNT_BITS-1:0]     occ_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [63:0]                         rsp_data_ff;
   logic [63:0]                         rsp_data_in;
   wspq_pkg::status_type                rsp_status_ff;
   wspq_pkg::status_type                rsp_status_in;

   logic                                accept;
   logic                                is_full;
   logic                                is_empty;
   wspq_pkg::op_type                    op;
   wspq_pkg::cmd_type                   cmd;
   wspq_pkg::entry_type                 head;

   logic                                keep      [N];
   wspq_pkg::entry_type                 entries   [N];
   logic                                valid     [N];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign op         = wspq_pkg::op_type'(req_tuser);
   assign is_full    = occ_ff == wspq_pkg::COUNT_BITS'(N);
   assign is_empty   = occ_ff == '0;

   always_comb begin
      cmd.item.weight = req_tdata[31:0];
      cmd.item.symbol = req_tdata[39:32];
      cmd.item.handle = wspq_pkg::HANDLE_BITS'(req_tdata[48:40]);
      cmd.shift_in    = accept && (op == wspq_pkg::OP_ENQUEUE) && !is_full;
      cmd.shift_out   = accept && (op == wspq_pkg::OP_DEQUEUE) && !is_empty;
   end

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         assign valid[i] = occ_ff > wspq_pkg::COUNT_BITS'(i);
         wspq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .slot_valid (valid[i]),
            .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .prev_entry (entries[(i == 0) ? 0 : i - 1]),
            .next_entry (entries[(i == N - 1) ? N - 1 : i + 1]),
            .keep       (keep[i]),
            .entry      (entries[i])
         );
      end
   endgenerate

   assign head = entries[0];

   always_comb begin
      occ_in = occ_ff;
      if (cmd.shift_in) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.shift_out) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = wspq_pkg::STATUS_OK;
         if (op == wspq_pkg::OP_ENQUEUE) begin
            if (is_full) begin
               rsp_status_in = wspq_pkg::STATUS_FULL;
            end
         end else if (is_empty) begin
            rsp_status_in = wspq_pkg::STATUS_EMPTY;
         end else begin
            rsp_data_in[31:0]  = head.weight;
            rsp_data_in[39:32] = head.symbol;
            rsp_data_in[48:40] = wspq_pkg::FIELD_HANDLE'(head.handle);
         end
         rsp_data_in[57:49] = wspq_pkg::FIELD_COUNT'(occ_in);
         rsp_data_in[58]    = occ_in == '0;
         rsp_data_in[59]    = occ_in == wspq_pkg::COUNT_BITS'(1);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: design/wspq_cell.sv
// ----------------------------------------------------------------------------
// wspq_cell
// One slot of the sorted row. Keeps its entry, takes the new entry, or takes
// a neighbor's entry, depending on the broadcast command.
// ----------------------------------------------------------------------------
module wspq_cell (
   input  logic                clock,
   input  wspq_pkg::cmd_type   cmd,
   input  logic                slot_valid,
   input  logic                prev_keep,
   input  wspq_pkg::entry_type prev_entry,
   input  wspq_pkg::entry_type next_entry,
   output logic                keep,
   output wspq_pkg::entry_type entry
);

   wspq_pkg::entry_type entry_ff;
   wspq_pkg::entry_type entry_in;

   // keep: this slot holds an entry not greater than the new one
   assign keep  = slot_valid && !wspq_pkg::goes_before(cmd.item, entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_in) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = cmd.item;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.shift_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: tb/weight_symbol_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weight_symbol_priority_queue_top_tb
// Self-checking bench for the weight/symbol min-priority queue.
// A directed table covers the empty edge, extreme keys, weight ties and
// equal entries. Random traffic then fills the queue to capacity, hovers there,
// drains it below empty and mixes freely. Each response is checked against the
// table or an in-bench sorted-array model, with random stalls on both streams.
// ----------------------------------------------------------------------------
module weight_symbol_priority_queue_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TARGET_COUNT = 1650;

   typedef struct packed {
      wspq_pkg::status_type            status;
      wspq_pkg::entry_type             ent;
      logic [wspq_pkg::FIELD_COUNT-1:0] count;
      logic                            is_empty;
      logic                            is_one;
   } queue_rsp_type;

   typedef struct packed {
      wspq_pkg::op_type    op;
      wspq_pkg::entry_type ent;
      bit                  typed;
      queue_rsp_type       want;
   } stim_row_type;

   localparam wspq_pkg::entry_type NO_ENT = '0;
   localparam queue_rsp_type       NO_EXP = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;  // item_weight, item_symbol, item_handle, pad
   logic        req_tuser  = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // out_weight, out_symbol, out_handle,
                                  // entry_count, queue_empty, size_is_one, pad
   logic [1:0]  rsp_tuser;        // status

   wspq_pkg::entry_type sorted_mem [wspq_pkg::CAPACITY];
   int                  held_count  = 0;
   queue_rsp_type       pending_rsp [$];
   int                  error_count = 0;
   int                  sent_count  = 0;
   int                  cycle_count = 0;
   bit                  quiet       = 1'b0;

   stim_row_type directed_rows [23] = '{
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_EMPTY, NO_ENT, 9'd0, 1'b1, 1'b0}},
      '{wspq_pkg::OP_ENQUEUE, '{32'hFFFF_FFFF, 8'hFF, 9'h1FF}, 1'b1,
        '{wspq_pkg::STATUS_OK, NO_ENT, 9'd1, 1'b0, 1'b1}},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_OK, '{32'hFFFF_FFFF, 8'hFF, 9'h1FF}, 9'd0, 1'b1, 1'b0}},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_EMPTY, NO_ENT, 9'd0, 1'b1, 1'b0}},
      '{wspq_pkg::OP_ENQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_OK, NO_ENT, 9'd1, 1'b0, 1'b1}},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_OK, NO_ENT, 9'd0, 1'b1, 1'b0}},
      // weight ties: symbol decides, equal entries keep arrival order
      '{wspq_pkg::OP_ENQUEUE, '{32'd10, 8'd5, 9'd1}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'd10, 8'd3, 9'd2}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'd10, 8'd5, 9'd3}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'd9, 8'hFF, 9'd4}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'd10, 8'd5, 9'd5}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'hFFFF_FFFF, 8'd0, 9'd6}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'hAAAA_AAAA, 8'hAA, 9'h0AA}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_ENQUEUE, '{32'h5555_5555, 8'h55, 9'h155}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, '{32'h1234_5678, 8'h9A, 9'h1BC}, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b0, NO_EXP},
      '{wspq_pkg::OP_DEQUEUE, NO_ENT, 1'b1,
        '{wspq_pkg::STATUS_EMPTY, NO_ENT, 9'd0, 1'b1, 1'b0}}
   };

   weight_symbol_priority_queue_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // sorted insertion behind every entry not greater than the new one
   function automatic queue_rsp_type queue_apply(wspq_pkg::op_type op,
                                                 wspq_pkg::entry_type e);
      queue_rsp_type r;
      int            pos;
      int            i;
      r = '0;
      r.status = wspq_pkg::STATUS_OK;
      if (op == wspq_pkg::OP_ENQUEUE) begin
         if (held_count >= wspq_pkg::CAPACITY) begin
            r.status = wspq_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < held_count &&
                   !(e.weight < sorted_mem[pos].weight ||
                     (e.weight == sorted_mem[pos].weight &&
                      e.symbol < sorted_mem[pos].symbol))) begin
               pos++;
            end
            for (i = held_count; i > pos; i--) begin
               sorted_mem[i] = sorted_mem[i-1];
            end
            sorted_mem[pos] = e;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = wspq_pkg::STATUS_EMPTY;
         end else begin
            r.ent = sorted_mem[0];
            for (i = 0; i < held_count - 1; i++) begin
               sorted_mem[i] = sorted_mem[i+1];
            end
            held_count--;
         end
      end
      r.count    = wspq_pkg::FIELD_COUNT'(held_count);
      r.is_empty = (held_count == 0);
      r.is_one   = (held_count == 1);
      return r;
   endfunction

   function automatic wspq_pkg::entry_type random_entry();
      wspq_pkg::entry_type e;
      case ($urandom_range(0, 3))
         0: e.weight = $urandom_range(0, 7);
         1: e.weight = 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: e.weight = $urandom;
      endcase
      e.symbol = wspq_pkg::SYMBOL_BITS'(($urandom_range(0, 1) == 0) ?
                                        $urandom_range(0, 3) : $urandom_range(0, 255));
      e.handle = wspq_pkg::HANDLE_BITS'($urandom_range(0, 511));
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s at cycle %0d: got %0h expected %0h",
               what, cycle_count, got, want);
      error_count++;
   endtask

   task automatic send_request(wspq_pkg::op_type op, wspq_pkg::entry_type e, bit typed,
                               queue_rsp_type want);
      queue_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, e.handle, e.symbol, e.weight};
      do @(posedge clock); while (!req_tready);
      predicted = queue_apply(op, e);
      pending_rsp.push_back(typed ? want : predicted);
      sent_count++;
      if (!quiet && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_mixed(int enqueue_pct);
      send_request(($urandom_range(0, 99) < enqueue_pct) ?
                   wspq_pkg::OP_ENQUEUE : wspq_pkg::OP_DEQUEUE,
                   random_entry(), 1'b0, NO_EXP);
   endtask

   always @(posedge clock) begin
      queue_rsp_type want;
      cycle_count <= cycle_count + 1;
      rsp_tready  <= quiet || ($urandom_range(0, 99) >= 14);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response without request", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
            if (rsp_tdata[31:0] != want.ent.weight)
               report_mismatch("out_weight", rsp_tdata[31:0], want.ent.weight);
            if (rsp_tdata[39:32] != want.ent.symbol)
               report_mismatch("out_symbol", 32'(rsp_tdata[39:32]), 32'(want.ent.symbol));
            if (rsp_tdata[48:40] != want.ent.handle)
               report_mismatch("out_handle", 32'(rsp_tdata[48:40]), 32'(want.ent.handle));
            if (rsp_tdata[57:49] != want.count)
               report_mismatch("entry_count", 32'(rsp_tdata[57:49]), 32'(want.count));
            if (rsp_tdata[58] != want.is_empty)
               report_mismatch("queue_empty", 32'(rsp_tdata[58]), 32'(want.is_empty));
            if (rsp_tdata[59] != want.is_one)
               report_mismatch("size_is_one", 32'(rsp_tdata[59]), 32'(want.is_one));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].ent,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // hold off until the queue has answered everything
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);

      repeat (600) send_mixed(55);

      // back-to-back fill to capacity, then pushes into a full queue
      quiet = 1'b1;
      while (held_count < wspq_pkg::CAPACITY)
         send_request(wspq_pkg::OP_ENQUEUE, random_entry(), 1'b0, NO_EXP);
      repeat (4) send_request(wspq_pkg::OP_ENQUEUE, random_entry(), 1'b0, NO_EXP);
      quiet = 1'b0;

      repeat (150) send_mixed(50);

      while (held_count > 0)
         send_request(wspq_pkg::OP_DEQUEUE, random_entry(), 1'b0, NO_EXP);
      repeat (4) send_request(wspq_pkg::OP_DEQUEUE, random_entry(), 1'b0, NO_EXP);

      while (sent_count < TARGET_COUNT) send_mixed(52);

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/wspq_pkg.sv
design/wspq_cell.sv
design/weight_symbol_priority_queue_top.sv
tb/weight_symbol_priority_queue_top_tb.sv
